// ===== hw/rtl/svp_pkg.sv =====
package svp_pkg;

   localparam int MAX_FRAMES = 16384;
   localparam int MEM_WORDS  = 32768;
   localparam int FRAME_W    = 15;
   localparam int ADDR_W     = 15;
   localparam int PHASE_W    = 48;
   localparam int STEP_W     = 47;
   localparam int SAMPLE_W   = 24;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 47;

   localparam logic [1:0] OP_LOAD  = 2'd0;
   localparam logic [1:0] OP_START = 2'd1;
   localparam logic [1:0] OP_FRAME = 2'd2;

   localparam logic [2:0] CSR_START  = 3'd0;
   localparam logic [2:0] CSR_END    = 3'd1;
   localparam logic [2:0] CSR_MODE   = 3'd2;
   localparam logic [2:0] CSR_FIRST  = 3'd3;
   localparam logic [2:0] CSR_LAST   = 3'd4;
   localparam logic [2:0] CSR_STEP   = 3'd5;
   localparam logic [2:0] CSR_INTERP = 3'd6;
   localparam logic [2:0] CSR_FORMAT = 3'd7;

   localparam logic [1:0] MODE_ONCE = 2'd0;
   localparam logic [1:0] MODE_FWD  = 2'd1;
   localparam logic [1:0] MODE_PING = 2'd2;
   localparam logic [1:0] MODE_SEG  = 2'd3;

   // commands from controller to datapath
   typedef struct packed {
      logic load;        // write sample word
      logic start;       // check config and set up voice
      logic rd_a;        // issue memory read for current frame
      logic rd_b;        // issue memory read for next frame
      logic cap_a;       // capture read data of current frame
      logic cap_b;       // capture read data of next frame
      logic mul;         // interpolation multiply
      logic fin;         // build output samples
      logic adv;         // phase advance, first step
      logic mod_start;   // start modulo unit
      logic adv_done;    // commit advanced phase
      logic clear_out;   // output zeros
   } cmd_type;

   typedef struct packed {
      logic active;
      logic mod_busy;
      logic need_mod;
      logic side;        // 0 left, 1 right in progress
      logic stereo;
   } sts_type;

endpackage

// ===== hw/rtl/sample_voice_playback.sv =====
// channel  direction  payload
// req      in         tuser[1:0] op; tdata[14:0] word_address, [38:15] word_value
// rsp      out        tdata[23:0] left, [47:24] right, [48] status, [49] playing
// csr      in         csr_index 3 bit, csr_data 47 bit, one register per request
//
// load, start and op three offer the response right after the accepting edge
// a frame for an active voice steps each channel through read, capture, read, capture,
// multiply and output, then the phase advance, which waits on the 48-bit modulo by the
// loop cycle when it runs (one bit a cycle), before it offers its response
// reset is synchronous active high; the sample memory itself is not cleared
// a new request is taken only after the previous response has been taken
module sample_voice_playback (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // op
   input  logic [39:0] req_tdata,   // word_address, word_value, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // left_sample, right_sample, status, playing, pad
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [svp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [svp_pkg::CSR_DATA_W-1:0] csr_data
);
   import svp_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic    side;
   logic signed [SAMPLE_W-1:0] left_sample, right_sample;
   logic    status, playing;

   // configuration is always accepted
   assign csr_ready = 1'b1;

   svp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .op         (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .side       (side),
      .sts        (sts)
   );

   svp_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .side         (side),
      .sts          (sts),
      .word_address (req_tdata[14:0]),
      .word_value   (req_tdata[38:15]),
      .csr_valid    (csr_valid),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .left_sample  (left_sample),
      .right_sample (right_sample),
      .status       (status),
      .playing      (playing)
   );

   assign rsp_tdata = {6'd0, playing, status, right_sample, left_sample};

endmodule

// ===== hw/rtl/svp_ctrl.sv =====
module svp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [1:0]        op,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output svp_pkg::cmd_type  cmd,
   output logic              side,
   input  svp_pkg::sts_type  sts
);
   import svp_pkg::*;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_RDA  = 4'd1;
   localparam logic [3:0] ST_CAPA = 4'd2;
   localparam logic [3:0] ST_RDB  = 4'd3;
   localparam logic [3:0] ST_CAPB = 4'd4;
   localparam logic [3:0] ST_MUL  = 4'd5;
   localparam logic [3:0] ST_FIN  = 4'd6;
   localparam logic [3:0] ST_ADV  = 4'd7;
   localparam logic [3:0] ST_MOD  = 4'd8;
   localparam logic [3:0] ST_DONE = 4'd9;
   localparam logic [3:0] ST_OUT  = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       side_ff, side_in;
   logic       wait_ff, wait_in;

   assign side       = side_ff;
   assign req_tready = (state_ff == ST_IDLE) && !rsp_tvalid;
   assign rsp_tvalid = (state_ff == ST_OUT);

   always_comb begin
      state_in = state_ff;
      side_in  = side_ff;
      wait_in  = 1'b0;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               unique case (op)
                  OP_LOAD: begin
                     cmd.load  = 1'b1;
                     cmd.clear_out = 1'b1;
                     state_in  = ST_OUT;
                  end
                  OP_START: begin
                     cmd.start = 1'b1;
                     cmd.clear_out = 1'b1;
                     state_in  = ST_OUT;
                  end
                  OP_FRAME: begin
                     cmd.clear_out = 1'b1;
                     side_in  = 1'b0;
                     state_in = sts.active ? ST_RDA : ST_OUT;
                  end
                  default: begin
                     cmd.clear_out = 1'b1;
                     state_in = ST_OUT;
                  end
               endcase
            end
         end
         ST_RDA: begin
            cmd.rd_a = 1'b1;
            state_in = ST_CAPA;
         end
         ST_CAPA: begin
            cmd.cap_a = 1'b1;
            state_in = ST_RDB;
         end
         ST_RDB: begin
            cmd.rd_b = 1'b1;
            state_in = ST_CAPB;
         end
         ST_CAPB: begin
            cmd.cap_b = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            cmd.fin = 1'b1;
            if (!side_ff && sts.stereo) begin
               side_in  = 1'b1;
               state_in = ST_RDA;
            end else begin
               state_in = ST_ADV;
            end
         end
         ST_ADV: begin
            cmd.adv  = 1'b1;
            state_in = ST_MOD;
            wait_in  = 1'b1;
         end
         ST_MOD: begin
            if (wait_ff) begin
               if (sts.need_mod) begin
                  cmd.mod_start = 1'b1;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (!sts.mod_busy) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            cmd.adv_done = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         side_ff  <= 1'b0;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         side_ff  <= side_in;
         wait_ff  <= wait_in;
      end
   end

endmodule

// ===== hw/rtl/svp_mod.sv =====
module svp_mod (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [svp_pkg::PHASE_W-1:0] dividend,
   input  logic [svp_pkg::PHASE_W-1:0] divisor,
   output logic                       busy,
   output logic [svp_pkg::PHASE_W-1:0] remainder
);
   import svp_pkg::*;

   localparam int CNT_W = $clog2(PHASE_W + 1);

   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic [PHASE_W-1:0] quo_ff, quo_in;
   logic [PHASE_W:0]   rem_ff, rem_in;
   logic [PHASE_W-1:0] div_ff, div_in;
   logic [PHASE_W:0]   trial;

   assign busy      = busy_ff;
   assign remainder = rem_ff[PHASE_W-1:0];
   assign trial     = {rem_ff[PHASE_W-1:0], quo_ff[PHASE_W-1]};

   // restoring remainder, one bit a cycle
   always_comb begin
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(PHASE_W);
         quo_in  = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[PHASE_W-2:0], 1'b0};
         if (trial >= {1'b0, div_ff}) rem_in = trial - {1'b0, div_ff};
         else rem_in = trial;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

endmodule

// ===== hw/rtl/svp_datapath.sv =====
module svp_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  svp_pkg::cmd_type              cmd,
   input  logic                          side,
   output svp_pkg::sts_type              sts,
   input  logic [svp_pkg::ADDR_W-1:0]    word_address,
   input  logic signed [svp_pkg::SAMPLE_W-1:0] word_value,
   input  logic                          csr_valid,
   input  logic [svp_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [svp_pkg::CSR_DATA_W-1:0] csr_data,
   output logic signed [svp_pkg::SAMPLE_W-1:0] left_sample,
   output logic signed [svp_pkg::SAMPLE_W-1:0] right_sample,
   output logic                          status,
   output logic                          playing
);
   import svp_pkg::*;

   localparam int FR1 = FRAME_W + 1;

   // configuration registers
   logic [FRAME_W-1:0] r_start_ff, r_end_ff, r_first_ff, r_last_ff;
   logic [1:0]         r_mode_ff;
   logic [STEP_W-1:0]  r_step_ff;
   logic               r_interp_ff;
   logic [2:0]         r_format_ff;

   // voice state
   logic [FRAME_W-1:0] v_end_ff, v_first_ff, v_last_ff;
   logic [STEP_W-1:0]  v_step_ff;
   logic [1:0]         v_mode_ff;
   logic               v_seg_ff, v_interp_ff, v_stereo_ff;
   logic [1:0]         v_code_ff;
   logic [PHASE_W-1:0] phase_ff, cycle_ff;
   logic               in_loop_ff, active_ff;

   logic [SAMPLE_W-1:0] mem [MEM_WORDS];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                rd_ok_ff;

   logic signed [SAMPLE_W:0]   a_ff, b_ff;
   logic signed [SAMPLE_W+33:0] prod_ff;
   logic signed [SAMPLE_W-1:0] left_ff, right_ff;
   logic                       status_ff;

   // phase advance working registers
   logic [PHASE_W-1:0] nphase_ff;
   logic               nloop_ff, nactive_ff;
   logic               need_mod_ff;
   logic [PHASE_W-1:0] mod_base_ff;
   logic               mod_kind_ff;   // 0 entering loop, 1 in loop

   logic               mod_busy;
   logic [PHASE_W-1:0] mod_rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_start_ff  <= '0;
         r_end_ff    <= '0;
         r_mode_ff   <= '0;
         r_first_ff  <= '0;
         r_last_ff   <= '0;
         r_step_ff   <= STEP_W'(64'h1_0000_0000);
         r_interp_ff <= 1'b0;
         r_format_ff <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_START:  r_start_ff  <= csr_data[FRAME_W-1:0];
            CSR_END:    r_end_ff    <= csr_data[FRAME_W-1:0];
            CSR_MODE:   r_mode_ff   <= csr_data[1:0];
            CSR_FIRST:  r_first_ff  <= csr_data[FRAME_W-1:0];
            CSR_LAST:   r_last_ff   <= csr_data[FRAME_W-1:0];
            CSR_STEP:   r_step_ff   <= csr_data[STEP_W-1:0];
            CSR_INTERP: r_interp_ff <= csr_data[0];
            CSR_FORMAT: r_format_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // start check
   logic [1:0] s_code;
   logic       s_ok;
   logic [FRAME_W-1:0] s_span;
   always_comb begin
      s_code = r_format_ff[2:1];
      s_span = r_last_ff - r_first_ff;
      s_ok   = (r_step_ff != '0) && (s_code != 2'd3);
      if (r_format_ff[0] && (MAX_FRAMES * 2 > MEM_WORDS)) s_ok = 1'b0;
      if (r_mode_ff == MODE_SEG) begin
         if (r_start_ff >= r_end_ff || r_end_ff > FRAME_W'(MAX_FRAMES)) s_ok = 1'b0;
         if (r_last_ff > FRAME_W'(MAX_FRAMES) || r_first_ff >= r_last_ff) s_ok = 1'b0;
      end else begin
         if (r_start_ff >= r_end_ff || r_end_ff > FRAME_W'(MAX_FRAMES)) s_ok = 1'b0;
         if (r_mode_ff == MODE_ONCE) begin
            if (r_first_ff != '0 || r_last_ff != '0) s_ok = 1'b0;
         end else if (r_first_ff < r_start_ff || r_last_ff > r_end_ff
                      || r_first_ff >= r_last_ff) begin
            s_ok = 1'b0;
         end
      end
   end

   // play position
   logic [PHASE_W-1:0] p;
   logic [FR1-1:0]     idx, nxt;
   logic [31:0]        frac;
   always_comb begin
      p = phase_ff;
      if (in_loop_ff) begin
         if (v_mode_ff == MODE_PING && p > (cycle_ff >> 1)) p = cycle_ff - p;
         p = p + {1'b0, v_first_ff, 32'd0};
      end
      idx  = p[PHASE_W-1:32];
      frac = p[31:0];
      nxt  = idx + 1'b1;
      if (v_seg_ff && !in_loop_ff) begin
         if (nxt == {1'b0, v_end_ff}) nxt = {1'b0, v_first_ff};
      end else if (v_mode_ff != MODE_ONCE && nxt == {1'b0, v_last_ff}) begin
         nxt = (v_mode_ff == MODE_FWD) ? {1'b0, v_first_ff} : idx;
      end else if (v_mode_ff == MODE_ONCE && nxt == {1'b0, v_end_ff}) begin
         nxt = idx;
      end
   end

   logic [FR1-1:0]  rd_frame;
   logic [FR1+1:0]  rd_addr;
   always_comb begin
      rd_frame = cmd.rd_b ? nxt : idx;
      rd_addr  = v_stereo_ff ? {1'b0, rd_frame, side} : {2'b00, rd_frame};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) mem[word_address] <= word_value;
      if (cmd.rd_a || cmd.rd_b) rd_data_ff <= mem[rd_addr[ADDR_W-1:0]];
      rd_ok_ff <= (rd_addr < (FR1+2)'(MEM_WORDS));
   end

   // width scaling
   logic signed [SAMPLE_W:0] scaled;
   always_comb begin
      unique case (v_code_ff)
         2'd0:    scaled = {rd_data_ff[7], rd_data_ff[7:0], 16'd0};
         2'd1:    scaled = {rd_data_ff[15], rd_data_ff[15:0], 8'd0};
         default: scaled = {rd_data_ff[SAMPLE_W-1], rd_data_ff};
      endcase
      if (!rd_ok_ff) scaled = '0;
   end

   // rounding of the interpolation correction
   logic [SAMPLE_W+33:0]       mag;
   logic signed [SAMPLE_W+1:0] corr;
   logic signed [SAMPLE_W+1:0] fin_val;
   always_comb begin
      mag  = prod_ff[SAMPLE_W+33] ? (SAMPLE_W+34)'(-prod_ff) : prod_ff;
      mag  = mag + (SAMPLE_W+34)'(33'h0_8000_0000);
      corr = (SAMPLE_W+2)'(mag[SAMPLE_W+33:32]);
      if (prod_ff[SAMPLE_W+33]) corr = -corr;
      fin_val = (v_interp_ff && frac != '0) ? (SAMPLE_W+2)'(a_ff) + corr
                                            : (SAMPLE_W+2)'(a_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_a) a_ff <= scaled;
      if (cmd.cap_b) b_ff <= scaled;
      if (cmd.mul) prod_ff <= (b_ff - a_ff) * $signed({1'b0, frac});
      if (cmd.clear_out) begin
         left_ff  <= '0;
         right_ff <= '0;
      end
      if (cmd.fin) begin
         if (!side) begin
            left_ff <= fin_val[SAMPLE_W-1:0];
            if (!v_stereo_ff) right_ff <= fin_val[SAMPLE_W-1:0];
         end else begin
            right_ff <= fin_val[SAMPLE_W-1:0];
         end
      end
   end

   // phase advance, first step
   logic [PHASE_W-1:0] distance, tgt, ext_step;
   always_comb begin
      ext_step = {1'b0, v_step_ff};
      tgt = {1'b0, ((v_seg_ff ? v_end_ff : (v_mode_ff == MODE_ONCE ? v_end_ff
                                                                   : v_first_ff))), 32'd0};
      distance = tgt - phase_ff;
   end

   logic [PHASE_W-1:0] mod_in;
   logic [PHASE_W-1:0] fin_phase;
   logic [PHASE_W-1:0] ldist;
   assign mod_in = mod_kind_ff ? ext_step : mod_base_ff;
   always_comb begin
      ldist = cycle_ff - phase_ff;
      fin_phase = nphase_ff;
      if (need_mod_ff) begin
         if (!mod_kind_ff) fin_phase = mod_rem;
         else fin_phase = (mod_rem >= ldist) ? mod_rem - ldist : phase_ff + mod_rem;
      end
   end

   svp_mod u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.mod_start),
      .dividend  (mod_in),
      .divisor   (cycle_ff),
      .busy      (mod_busy),
      .remainder (mod_rem)
   );

   always_ff @(posedge clock) begin
      if (cmd.adv) begin
         nphase_ff   <= phase_ff;
         nloop_ff    <= in_loop_ff;
         nactive_ff  <= active_ff;
         need_mod_ff <= 1'b0;
         mod_kind_ff <= 1'b0;
         mod_base_ff <= ext_step - distance;
         if (v_mode_ff == MODE_ONCE) begin
            if (ext_step >= distance) begin
               nactive_ff <= 1'b0;
               nphase_ff  <= tgt;
            end else begin
               nphase_ff <= phase_ff + ext_step;
            end
         end else if (!in_loop_ff) begin
            if (ext_step < distance) begin
               nphase_ff <= phase_ff + ext_step;
            end else begin
               nloop_ff  <= 1'b1;
               nphase_ff <= '0;
               need_mod_ff <= (cycle_ff != '0);
            end
         end else if (cycle_ff != '0) begin
            need_mod_ff <= 1'b1;
            mod_kind_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         cycle_ff    <= '0;
         in_loop_ff  <= 1'b0;
         active_ff   <= 1'b0;
         status_ff   <= 1'b0;
         v_end_ff    <= '0;
         v_first_ff  <= '0;
         v_last_ff   <= '0;
         v_step_ff   <= '0;
         v_mode_ff   <= MODE_ONCE;
         v_seg_ff    <= 1'b0;
         v_interp_ff <= 1'b0;
         v_stereo_ff <= 1'b0;
         v_code_ff   <= 2'd0;
      end else begin
         if (cmd.start) status_ff <= !s_ok;
         else if (cmd.clear_out) status_ff <= 1'b0;
         if (cmd.start) begin
            if (s_ok) begin
               v_end_ff    <= r_end_ff;
               v_first_ff  <= r_first_ff;
               v_last_ff   <= r_last_ff;
               v_step_ff   <= r_step_ff;
               v_interp_ff <= r_interp_ff;
               v_stereo_ff <= r_format_ff[0];
               v_code_ff   <= r_format_ff[2:1];
               v_seg_ff    <= (r_mode_ff == MODE_SEG);
               v_mode_ff   <= (r_mode_ff == MODE_SEG) ? MODE_FWD : r_mode_ff;
               active_ff   <= 1'b1;
               in_loop_ff  <= 1'b0;
               phase_ff    <= {1'b0, r_start_ff, 32'd0};
               cycle_ff    <= '0;
               if (r_mode_ff != MODE_ONCE) begin
                  if (r_mode_ff == MODE_PING)
                     cycle_ff <= {s_span - 1'b1, 33'd0};
                  else
                     cycle_ff <= {1'b0, s_span, 32'd0};
                  if (r_mode_ff != MODE_SEG && r_start_ff == r_first_ff) begin
                     in_loop_ff <= 1'b1;
                     phase_ff   <= '0;
                  end
               end
            end
         end
         if (cmd.adv_done) begin
            phase_ff   <= fin_phase;
            in_loop_ff <= nloop_ff;
            active_ff  <= nactive_ff;
         end
      end
   end

   assign sts.active   = active_ff;
   assign sts.mod_busy = mod_busy;
   assign sts.need_mod = need_mod_ff;
   assign sts.side     = side;
   assign sts.stereo   = v_stereo_ff;

   assign left_sample  = left_ff;
   assign right_sample = right_ff;
   assign status       = status_ff;
   assign playing      = active_ff;

endmodule
